@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DBA_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dba assertion failed");
`define DBA_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("dba assertion failed");
`else
`define DBA_ASSERT(label, clk, rst, prop)
`define DBA_ASSERT_NORST(label, clk, prop)
`endif
`endif

@@ rtl/core/dba_pkg.sv @@
// ----------------------------------------------------------------------------
// DropBlock mask unit package
// Shared configuration type, register indexes, reset values and states.
// ----------------------------------------------------------------------------
package dba_pkg;

  localparam int DBA_MAX_SIDE    = 64;
  localparam int DBA_MAX_BLOCK   = 7;
  localparam int DBA_QUEUE_DEPTH = 2;

  localparam logic [6:0]  DBA_RST_HEIGHT = 7'd64;
  localparam logic [6:0]  DBA_RST_WIDTH  = 7'd64;
  localparam logic [2:0]  DBA_RST_BLOCK  = 3'd3;
  localparam logic [14:0] DBA_RST_SCALE  = 15'd2048;

  // Q8.8 times Q4.11 gives Q.19; half of the dropped 11 bits rounds.
  localparam int DBA_FRAC_BITS = 11;
  localparam logic signed [31:0] DBA_HALF_ROUND = 32'sd1024;

  typedef enum logic [1:0] {
    REG_PLANE_HEIGHT,
    REG_PLANE_WIDTH,
    REG_DROP_BLOCK_SIZE,
    REG_KEEP_SCALE
  } reg_index_t;

  typedef struct packed {
    logic [6:0]  plane_height;
    logic [6:0]  plane_width;
    logic [2:0]  drop_block_size;
    logic [14:0] keep_scale;
  } cfg_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_WAIT,
    B_EMIT
  } back_state_t;

endpackage

@@ rtl/core/dba_queue.sv @@
// ----------------------------------------------------------------------------
// DropBlock item queue
// Small synchronous queue between the classifying front and the back end.
// ----------------------------------------------------------------------------
module dba_queue #(
  parameter int Width = 8,
  parameter int Depth = dba_pkg::DBA_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [Width-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [Width-1:0] pop_data
);
  import dba_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] entries [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CntW'(Depth));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

@@ rtl/core/dba_front.sv @@
// ----------------------------------------------------------------------------
// DropBlock front end
// Tracks the raster position, classifies requests and works out the clipped
// seed window of each data pixel before it is queued.
// ----------------------------------------------------------------------------
module dba_front #(
  parameter int MaxSide  = dba_pkg::DBA_MAX_SIDE,
  parameter int MaxBlock = dba_pkg::DBA_MAX_BLOCK,
  parameter int ItemW    = 20 + 4 * $clog2(dba_pkg::DBA_MAX_SIDE)
) (
  input  logic              clk,
  input  logic              rst,
  input  dba_pkg::cfg_t     cfg,
  input  logic              pos_clear,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_command,
  input  logic              in_seed_bit,
  input  logic signed [15:0] in_pixel,
  output logic              item_valid,
  input  logic              item_ready,
  output logic [ItemW-1:0]  item_data
);
  import dba_pkg::*;

  localparam int PW      = $clog2(MaxSide);
  localparam int SW      = PW + 1;
  localparam int BW      = PW + 3;
  localparam int HalfMax = (MaxBlock - 1) / 2;

  typedef struct packed {
    logic               is_data;
    logic               seed_bit;
    logic signed [15:0] pixel;
    logic               plane_end;
    logic               win_empty;
    logic [PW-1:0]      row_lo;
    logic [PW-1:0]      row_hi;
    logic [PW-1:0]      col_lo;
    logic [PW-1:0]      col_hi;
  } item_t;

  logic [PW-1:0]        row;
  logic [PW-1:0]        col;
  logic [PW-1:0]        row_next;
  logic [PW-1:0]        col_next;
  logic [SW-1:0]        hgt;
  logic [SW-1:0]        wid;
  logic [2:0]           bs_m1;
  logic [1:0]           half;
  logic signed [BW-1:0] r_s, c_s, h_s, hgt_s, wid_s;
  logic signed [BW-1:0] rlo, rhi, clo, chi;
  logic signed [BW-1:0] r_min, r_max, c_min, c_max;
  logic                 accept;
  item_t                item;

  assign in_ready   = item_ready;
  assign item_valid = in_valid;
  assign accept     = in_valid && item_ready;

  // Out-of-range plane sizes are clamped to 1..MaxSide.
  always_comb begin
    if (cfg.plane_height == '0) begin
      hgt = SW'(1);
    end else if (int'(cfg.plane_height) > MaxSide) begin
      hgt = SW'(MaxSide);
    end else begin
      hgt = SW'(cfg.plane_height);
    end
    if (cfg.plane_width == '0) begin
      wid = SW'(1);
    end else if (int'(cfg.plane_width) > MaxSide) begin
      wid = SW'(MaxSide);
    end else begin
      wid = SW'(cfg.plane_width);
    end
  end

  // Half block: a zero size acts as one, an even size as the odd one below.
  always_comb begin
    bs_m1 = cfg.drop_block_size - 3'd1;
    if (cfg.drop_block_size == '0) begin
      half = '0;
    end else if (int'(bs_m1[2:1]) > HalfMax) begin
      half = 2'(HalfMax);
    end else begin
      half = bs_m1[2:1];
    end
  end

  // Window around the pixel, clipped to the interior where seeds count.
  always_comb begin
    r_s   = signed'(BW'(row));
    c_s   = signed'(BW'(col));
    h_s   = signed'(BW'(half));
    hgt_s = signed'(BW'(hgt));
    wid_s = signed'(BW'(wid));
    r_min = r_s - h_s;
    r_max = r_s + h_s;
    c_min = c_s - h_s;
    c_max = c_s + h_s;
    rlo   = (r_min < h_s) ? h_s : r_min;
    rhi   = (r_max > hgt_s - BW'(1) - h_s) ? hgt_s - BW'(1) - h_s : r_max;
    clo   = (c_min < h_s) ? h_s : c_min;
    chi   = (c_max > wid_s - BW'(1) - h_s) ? wid_s - BW'(1) - h_s : c_max;
  end

  always_comb begin
    item.is_data   = in_command;
    item.seed_bit  = in_seed_bit;
    item.pixel     = in_pixel;
    item.plane_end = (SW'(row) == hgt - SW'(1)) && (SW'(col) == wid - SW'(1));
    item.win_empty = (rlo > rhi) || (clo > chi);
    // A seed load carries its write address in the low bounds.
    item.row_lo    = in_command ? rlo[PW-1:0] : row;
    item.row_hi    = rhi[PW-1:0];
    item.col_lo    = in_command ? clo[PW-1:0] : col;
    item.col_hi    = chi[PW-1:0];
    item_data      = item;
  end

  always_comb begin
    if (SW'(col) + SW'(1) >= wid) begin
      col_next = '0;
      row_next = (SW'(row) + SW'(1) >= hgt) ? '0 : row + 1'b1;
    end else begin
      col_next = col + 1'b1;
      row_next = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || pos_clear) begin
      row <= '0;
      col <= '0;
    end else if (accept) begin
      row <= row_next;
      col <= col_next;
    end
  end

endmodule

@@ rtl/core/dba_back.sv @@
// ----------------------------------------------------------------------------
// DropBlock back end
// Holds the seed plane, scans the window one seed row per cycle and scales
// the kept pixel with rounding and saturation.
// ----------------------------------------------------------------------------
module dba_back #(
  parameter int MaxSide = dba_pkg::DBA_MAX_SIDE,
  parameter int ItemW   = 20 + 4 * $clog2(dba_pkg::DBA_MAX_SIDE)
) (
  input  logic               clk,
  input  logic               rst,
  input  dba_pkg::cfg_t      cfg,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic [ItemW-1:0]   item_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_dropped,
  output logic [14:0]        out_mask,
  output logic               out_keep,
  output logic               out_last
);
  import dba_pkg::*;

  localparam int PW = $clog2(MaxSide);

  typedef struct packed {
    logic               is_data;
    logic               seed_bit;
    logic signed [15:0] pixel;
    logic               plane_end;
    logic               win_empty;
    logic [PW-1:0]      row_lo;
    logic [PW-1:0]      row_hi;
    logic [PW-1:0]      col_lo;
    logic [PW-1:0]      col_hi;
  } item_t;

  back_state_t         state;
  back_state_t         state_next;
  item_t               item;
  logic [MaxSide-1:0]  seed_mem [MaxSide];
  logic [MaxSide-1:0]  row_q;
  logic [MaxSide-1:0]  col_mask;
  logic [PW-1:0]       cur_row;
  logic [PW-1:0]       row_hi;
  logic [PW-1:0]       col_lo;
  logic [PW-1:0]       col_hi;
  logic                last;
  logic                hit;
  logic                rd_pend;
  logic signed [31:0]  prod;
  logic signed [31:0]  rounded;
  logic signed [20:0]  quot;
  logic signed [15:0]  sat;
  logic                mem_we;
  logic                mem_re;
  logic                start;
  logic                emit;

  assign item = item_t'(item_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    start      = 1'b0;
    emit       = 1'b0;
    unique case (state)
      B_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          if (item.is_data) begin
            start      = 1'b1;
            state_next = item.win_empty ? B_EMIT : B_SCAN;
          end else begin
            mem_we = 1'b1;
          end
        end
      end
      B_SCAN: begin
        mem_re = 1'b1;
        if (cur_row == row_hi) begin
          state_next = B_WAIT;
        end
      end
      B_WAIT: begin
        state_next = B_EMIT;
      end
      B_EMIT: begin
        if (!out_valid || out_ready) begin
          emit       = 1'b1;
          state_next = B_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    for (int j = 0; j < MaxSide; j++) begin
      col_mask[j] = (PW'(j) >= col_lo) && (PW'(j) <= col_hi);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      seed_mem[item.row_lo][item.col_lo] <= item.seed_bit;
    end
    if (mem_re) begin
      row_q <= seed_mem[cur_row];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= mem_re;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cur_row <= item.row_lo;
      row_hi  <= item.row_hi;
      col_lo  <= item.col_lo;
      col_hi  <= item.col_hi;
      last    <= item.plane_end;
      prod    <= item.pixel * signed'({1'b0, cfg.keep_scale});
    end else if (mem_re) begin
      cur_row <= cur_row + 1'b1;
    end
    if (start) begin
      hit <= 1'b0;
    end else if (rd_pend && (|(row_q & col_mask))) begin
      hit <= 1'b1;
    end
  end

  // Round half up to Q8.8 by a floor shift, then saturate.
  always_comb begin
    rounded = prod + DBA_HALF_ROUND;
    quot    = rounded[31:DBA_FRAC_BITS];
    if (quot > 21'sd32767) begin
      sat = 16'sh7fff;
    end else if (quot < -21'sd32768) begin
      sat = -16'sh8000;
    end else begin
      sat = quot[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_dropped <= hit ? '0 : sat;
      out_mask    <= hit ? '0 : cfg.keep_scale;
      out_keep    <= !hit;
      out_last    <= last;
    end
  end

endmodule

@@ rtl/core/dropblock_mask_apply_unit.sv @@
// ----------------------------------------------------------------------------
// DropBlock mask apply unit
// Seed plane load followed by masked, scaled streaming of feature planes.
// ----------------------------------------------------------------------------
// A seed load request is written in the idle state. A data pixel goes from
// idle to emit if its clipped seed window is empty, and otherwise through
// scan, wait and emit, reading up to MAX_BLOCK rows, because the seed plane
// sits in a memory with a single read port that returns one seed row per
// cycle. The front end keeps accepting requests into a two-entry queue while
// the back end works, and a result waits in an output register. The seed
// memory has no reset: load a full seed plane before sending pixels. Writing
// plane_height or plane_width restarts the raster at the origin.
`include "assert_macros.svh"

module dropblock_mask_apply_unit #(
  parameter int MAX_SIDE  = dba_pkg::DBA_MAX_SIDE,
  parameter int MAX_BLOCK = dba_pkg::DBA_MAX_BLOCK
) (
  input  logic        clk,
  input  logic        rst,
  // APB-style configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] seed_bit, [16:1] pixel_value, [23:17] zero
  input  logic [23:0] s_axis_tdata,
  // [0] command
  input  logic        s_axis_tuser,
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] dropped_value, [30:16] mask_value, [31] zero
  output logic [31:0] m_axis_tdata,
  // [0] keep_flag
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);
  import dba_pkg::*;

  localparam int ItemW = 20 + 4 * $clog2(MAX_SIDE);

  cfg_t               cfg;
  reg_index_t         reg_idx;
  logic               cfg_wr;
  logic               pos_clear;
  logic               f_valid, f_ready;
  logic [ItemW-1:0]   f_data;
  logic               q_valid, q_ready;
  logic [ItemW-1:0]   q_data;
  logic signed [15:0] out_dropped;
  logic [14:0]        out_mask;

  assign pready  = 1'b1;
  assign reg_idx = reg_index_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pos_clear = cfg_wr &&
                     (reg_idx == REG_PLANE_HEIGHT || reg_idx == REG_PLANE_WIDTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.plane_height    <= DBA_RST_HEIGHT;
      cfg.plane_width     <= DBA_RST_WIDTH;
      cfg.drop_block_size <= DBA_RST_BLOCK;
      cfg.keep_scale      <= DBA_RST_SCALE;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PLANE_HEIGHT:    cfg.plane_height    <= pwdata[6:0];
        REG_PLANE_WIDTH:     cfg.plane_width     <= pwdata[6:0];
        REG_DROP_BLOCK_SIZE: cfg.drop_block_size <= pwdata[2:0];
        REG_KEEP_SCALE:      cfg.keep_scale      <= pwdata[14:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PLANE_HEIGHT:    prdata = {25'd0, cfg.plane_height};
      REG_PLANE_WIDTH:     prdata = {25'd0, cfg.plane_width};
      REG_DROP_BLOCK_SIZE: prdata = {29'd0, cfg.drop_block_size};
      REG_KEEP_SCALE:      prdata = {17'd0, cfg.keep_scale};
    endcase
  end

  dba_front #(
    .MaxSide  (MAX_SIDE),
    .MaxBlock (MAX_BLOCK),
    .ItemW    (ItemW)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .pos_clear   (pos_clear),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_command  (s_axis_tuser),
    .in_seed_bit (s_axis_tdata[0]),
    .in_pixel    (s_axis_tdata[16:1]),
    .item_valid  (f_valid),
    .item_ready  (f_ready),
    .item_data   (f_data)
  );

  dba_queue #(
    .Width (ItemW),
    .Depth (DBA_QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  dba_back #(
    .MaxSide (MAX_SIDE),
    .ItemW   (ItemW)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item_valid  (q_valid),
    .item_ready  (q_ready),
    .item_data   (q_data),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_dropped (out_dropped),
    .out_mask    (out_mask),
    .out_keep    (m_axis_tuser),
    .out_last    (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_mask, out_dropped};

  // A dropped pixel carries neither value nor scale.
  `DBA_ASSERT(a_drop_is_zero, clk, rst, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 32'd0)
  // A kept pixel reports the programmed keep scale as its mask.
  `DBA_ASSERT(a_keep_mask, clk, rst, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[30:16] == cfg.keep_scale)
  // Reset empties the output register.
  `DBA_ASSERT_NORST(a_rst_clears_out, clk, rst |=> !m_axis_tvalid)

endmodule
